// ===== rtl/fbba_pkg.sv =====
// free block bitmap allocator: shared types, codes and constants
// used by the interfaces, the row unit and the top level; depends on nothing
`default_nettype none

package fbba_pkg;

    // default map size in blocks
    localparam int DEF_MAX_BLOCKS = 1024;

    // bitmap row width and bit position width
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    // field widths
    localparam int REQ_W     = 2;
    localparam int TARGET_W  = 10;
    localparam int GRANT_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 11;
    localparam int INODE_W   = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // register reset values
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1024);
    localparam logic [INODE_W-1:0] INODE_RESET = INODE_W'(1);

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INIT    = 2'd0,
        REQ_ALLOC   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_RESERVE = 2'd3
    } req_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADIDX  = 2'd2
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_BLOCKS      = 1'd0,
        CFG_INODE_BLOCK_COUNT = 1'd1
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_RMW,
        S_DONE
    } fsm_t;

    // lowest free bit found in one bitmap row
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } row_hit_t;

endpackage

`default_nettype wire

// ===== rtl/fbba_req_if.sv =====
// request channel: valid/ready handshake carrying one allocator request
// depends on fbba_pkg
`default_nettype none

interface fbba_req_if
    import fbba_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [TARGET_W-1:0] target_block;

    modport source (output valid, output req_type, output target_block, input ready);
    modport sink   (input valid, input req_type, input target_block, output ready);

endinterface

`default_nettype wire

// ===== rtl/fbba_resp_if.sv =====
// response channel: valid/ready handshake carrying one allocator result
// depends on fbba_pkg
`default_nettype none

interface fbba_resp_if
    import fbba_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [GRANT_W-1:0]  granted_block;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_block, output status, input ready);
    modport sink   (input valid, input granted_block, input status, output ready);

endinterface

`default_nettype wire

// ===== rtl/fbba_row_unit.sv =====
// shared row unit: builds the in-range mask of one bitmap row and finds
// the lowest set bit of the masked row; depends on fbba_pkg
`default_nettype none

module fbba_row_unit
    import fbba_pkg::*;
#(
    parameter int ROW_W = 5,
    parameter int IDX_W = 11
) (
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [IDX_W-1:0]  lo,
    input  wire logic [IDX_W-1:0]  hi,
    input  wire logic [WORD_W-1:0] data,
    output logic      [WORD_W-1:0] mask,
    output row_hit_t               hit
);

    logic [IDX_W-1:0]  base;
    logic [WORD_W-1:0] ge_lo;
    logic [WORD_W-1:0] ge_hi;
    logic [WORD_W-1:0] masked;

    // bits of the row whose block index is at or above x
    function automatic logic [WORD_W-1:0] ge_mask(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0]  d;
        logic [WORD_W-1:0] m;
        d = x - b;
        if (x <= b)
        begin
            m = '1;
        end
        else if (d >= IDX_W'(WORD_W))
        begin
            m = '0;
        end
        else
        begin
            m = {WORD_W{1'b1}} << d[BIT_W-1:0];
        end
        return m;
    endfunction

    // first block index of the row
    assign base = IDX_W'({row, {BIT_W{1'b0}}});

    // blocks in lo .. hi-1
    assign ge_lo  = ge_mask(lo, base);
    assign ge_hi  = ge_mask(hi, base);
    assign mask   = ge_lo & ~ge_hi;
    assign masked = data & mask;

    // lowest set bit
    always_comb
    begin
        hit.found   = |masked;
        hit.bit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (masked[j])
            begin
                hit.bit_pos = BIT_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/free_block_bitmap_allocator.sv =====
// free block bitmap allocator
//
// Requests arrive as beats on the req channel (init, allocate, release,
// reserve); each request gives exactly one beat on the resp channel with
// the granted block and a status. The free map sits in a memory of
// 32-bit rows (1 = free), ceil(MAX_BLOCKS/32) rows deep, worked on one row
// a cycle by a shared mask and first-set unit under a small sequencer.
// One request is worked on at a time; req.ready is high only while the
// sequencer is idle. A finished result waits in an output register, so
// the next request is taken while the receiver stalls; the sequencer only
// holds its next result until that register frees.
// After reset a clearing pass writes every row to in-use, one row a cycle,
// with no request taken; config writes on cfg_we/cfg_index/cfg_data are
// taken at any time and must come while idle.
// Depends on fbba_pkg, fbba_req_if, fbba_resp_if and fbba_row_unit.
`default_nettype none

module free_block_bitmap_allocator
    import fbba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    fbba_req_if.sink                   req,
    fbba_resp_if.source                resp
);

    localparam int DEPTH = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_A = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (IDX_A > TOTAL_W) ? IDX_A : TOTAL_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DEPTH - 1);

    // configuration registers
    logic [TOTAL_W-1:0] total_reg;
    logic [INODE_W-1:0] inode_reg;

    // sequencer registers
    fsm_t                state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_W-1:0]    chk_row_reg, chk_row_next;
    logic                chk_valid_reg, chk_valid_next;
    req_t                kind_reg, kind_next;
    logic [TARGET_W-1:0] tgt_reg, tgt_next;
    logic [GRANT_W-1:0]  res_granted_reg, res_granted_next;
    status_t             res_status_reg, res_status_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [GRANT_W-1:0]  out_granted_reg, out_granted_next;
    status_t             out_status_reg, out_status_next;

    // bitmap memory
    logic [WORD_W-1:0] map_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ROW_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    // derived values
    logic [IDX_W-1:0]  eff_size;
    logic [IDX_W-1:0]  eff_m1;
    logic [ROW_W-1:0]  last_row;
    logic [IDX_W-1:0]  in_tgt_idx;
    logic [IDX_W-1:0]  tgt_idx;
    logic              in_bad;
    logic [IDX_W-1:0]  grant_idx;
    logic [WORD_W-1:0] tgt_onehot;
    logic [WORD_W-1:0] hit_onehot;
    logic              out_free;

    // row unit connections
    logic [ROW_W-1:0]  unit_row;
    logic [IDX_W-1:0]  unit_lo;
    logic [WORD_W-1:0] unit_mask;
    row_hit_t          unit_hit;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            inode_reg <= INODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOTAL_BLOCKS:      total_reg <= cfg_data[TOTAL_W-1:0];
                CFG_INODE_BLOCK_COUNT: inode_reg <= cfg_data[INODE_W-1:0];
                default:               ;
            endcase
        end
    end

    // size saturated at MAX_BLOCKS and the last row to scan
    always_comb
    begin
        if (IDX_W'(total_reg) > IDX_W'(MAX_BLOCKS))
        begin
            eff_size = IDX_W'(MAX_BLOCKS);
        end
        else
        begin
            eff_size = IDX_W'(total_reg);
        end
        eff_m1   = eff_size - IDX_W'(1);
        last_row = (eff_size == '0) ? '0 : eff_m1[BIT_W +: ROW_W];
    end

    // target checks and bit selects
    assign in_tgt_idx = IDX_W'(req.target_block);
    assign in_bad     = (req.target_block == '0) || (in_tgt_idx >= eff_size);
    assign tgt_idx    = IDX_W'(tgt_reg);
    assign tgt_onehot = WORD_W'(1) << tgt_reg[BIT_W-1:0];
    assign hit_onehot = WORD_W'(1) << unit_hit.bit_pos;
    assign grant_idx  = IDX_W'({chk_row_reg, unit_hit.bit_pos});
    assign out_free   = !out_valid_reg || resp.ready;

    // row unit operand select: init sweep or allocate scan
    always_comb
    begin
        if (state_reg == S_INIT)
        begin
            unit_row = row_reg;
            unit_lo  = IDX_W'(inode_reg) + IDX_W'(1);
        end
        else
        begin
            unit_row = chk_row_reg;
            unit_lo  = IDX_W'(1);
        end
    end

    fbba_row_unit #(
        .ROW_W (ROW_W),
        .IDX_W (IDX_W)
    ) u_row_unit (
        .row  (unit_row),
        .lo   (unit_lo),
        .hi   (eff_size),
        .data (rd_data_reg),
        .mask (unit_mask),
        .hit  (unit_hit)
    );

    // bitmap memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_reg       <= '0;
            chk_row_reg   <= '0;
            chk_valid_reg <= 1'b0;
            kind_reg      <= REQ_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            chk_row_reg   <= chk_row_next;
            chk_valid_reg <= chk_valid_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg         <= tgt_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        chk_row_next     = chk_row_reg;
        chk_valid_next   = chk_valid_reg;
        kind_next        = kind_reg;
        tgt_next         = tgt_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !resp.ready;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = row_reg;
        mem_raddr        = row_reg;
        mem_wdata        = '0;
        req.ready        = 1'b0;

        case (state_reg)
            // sweep every row to in-use after reset
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = row_reg;
                mem_wdata = '0;
                if (row_reg == LAST_ROW)
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end

            // take a request beat
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kind_next        = req_t'(req.req_type);
                    tgt_next         = req.target_block;
                    res_granted_next = '0;
                    res_status_next  = ST_OK;
                    row_next         = '0;
                    chk_valid_next   = 1'b0;
                    case (req_t'(req.req_type))
                        REQ_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        REQ_ALLOC:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (in_bad)
                            begin
                                res_status_next = ST_BADIDX;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_tgt_idx[BIT_W +: ROW_W];
                                state_next = S_RMW;
                            end
                        end
                    endcase
                end
            end

            // rebuild every row from the size and inode count
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = row_reg;
                mem_wdata = unit_mask;
                if (row_reg == LAST_ROW)
                begin
                    row_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end

            // read rows in turn, check each one in the cycle after its read
            S_SCAN:
            begin
                if (chk_valid_reg && unit_hit.found)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = chk_row_reg;
                    mem_wdata        = rd_data_reg & ~hit_onehot;
                    res_granted_next = grant_idx[GRANT_W-1:0];
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                end
                else if (chk_valid_reg && (chk_row_reg == last_row))
                begin
                    res_granted_next = '0;
                    res_status_next  = ST_NOSPACE;
                    state_next       = S_DONE;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = row_reg;
                    chk_row_next   = row_reg;
                    chk_valid_next = 1'b1;
                    if (row_reg != last_row)
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end

            // write back the target row with one bit changed
            S_RMW:
            begin
                mem_we    = 1'b1;
                mem_waddr = tgt_idx[BIT_W +: ROW_W];
                if (kind_reg == REQ_RELEASE)
                begin
                    mem_wdata = rd_data_reg | tgt_onehot;
                end
                else
                begin
                    mem_wdata = rd_data_reg & ~tgt_onehot;
                end
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response channel
    assign resp.valid         = out_valid_reg;
    assign resp.granted_block = out_granted_reg;
    assign resp.status        = out_status_reg;

`ifndef SYNTH
    // one request at a time: no beat right after an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");

    // the scan never checks a row past the last row of the disk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && chk_valid_reg) |-> (chk_row_reg <= last_row))
        else $error("scan beyond last row");

    // a no-space result never carries a block
    assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && resp.status == ST_NOSPACE) |-> (resp.granted_block == '0))
        else $error("no-space result with a block");

    // a result leaves the sequencer only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !resp.ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire
